>>> src/rv32im_instruction_executor_defines.svh
// Assertion macros for the RV32IM executor
`ifndef RV32IM_INSTRUCTION_EXECUTOR_DEFINES_SVH
`define RV32IM_INSTRUCTION_EXECUTOR_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define RVX_ASSERT_IMP(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("assertion failed");
`define RVX_ASSERT_NXT(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("assertion failed");
`else
`define RVX_ASSERT_IMP(label, clk, rst, a, c)
`define RVX_ASSERT_NXT(label, clk, rst, a, c)
`endif
`endif

>>> src/rvx_pkg.sv
// Shared types and constants for the RV32IM executor
package rvx_pkg;
  localparam int NumRegsDefault = 32;
  localparam logic [31:0] VendorId = 32'h6b63757f;
  localparam logic [11:0] CsrMvendorid = 12'hF11;

  typedef enum logic [2:0] {
    K_RETIRE = 3'd0, K_LOAD = 3'd1, K_STORE = 3'd2, K_ILLEGAL = 3'd3,
    K_ECALL = 3'd4, K_EBREAK = 3'd5, K_UNEXPECTED = 3'd6
  } kind_t;

  typedef enum logic [2:0] {
    S_IDLE, S_READ, S_EXEC, S_MUL, S_DIV, S_OUT
  } state_t;

  localparam logic [4:0] OP_LOAD = 5'h00, OP_FENCE = 5'h03, OP_IMM = 5'h04,
    OP_AUIPC = 5'h05, OP_STORE = 5'h08, OP_OP = 5'h0C, OP_LUI = 5'h0D,
    OP_BRANCH = 5'h18, OP_JALR = 5'h19, OP_JAL = 5'h1B, OP_SYSTEM = 5'h1C;
  localparam logic [6:0] F7_ALT = 7'b0100000, F7_MUL = 7'b0000001;

  typedef struct packed {
    logic [2:0] kind;
    logic [31:0] mem_addr;
    logic [31:0] store_data;
    logic [1:0] access_size;
    logic [31:0] next_pc;
    logic reg_written;
    logic [4:0] dest_reg;
    logic [31:0] dest_value;
  } result_t;

  typedef struct packed {
    logic start;
    logic is_signed;
    logic rem;
    logic [31:0] a;
    logic [31:0] b;
  } div_req_t;
endpackage

>>> src/rvx_if.sv
// Valid/ready channel interface
interface rvx_if #(parameter type T = logic) (input logic clk);
  logic valid;
  logic ready;
  T data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

>>> src/rvx_ram.sv
// Generic single-write, dual-read RAM with registered read
module rvx_ram #(
  parameter int Width = 32,
  parameter int Depth = 32
) (
  input  logic clk,
  input  logic we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0] wdata,
  input  logic [$clog2(Depth)-1:0] raddr_a,
  input  logic [$clog2(Depth)-1:0] raddr_b,
  output logic [Width-1:0] rdata_a,
  output logic [Width-1:0] rdata_b
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end
endmodule

>>> src/rvx_div.sv
// Radix-2 restoring divider, one quotient bit per cycle
module rvx_div
  import rvx_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  div_req_t req,
  output logic done,
  output logic [31:0] result
);
  logic [31:0] quo, dvs, rem;
  logic [5:0] cnt;
  logic busy, neg_q, neg_r, want_rem;
  logic [32:0] trial;
  logic [31:0] rem_sh;
  logic [31:0] abs_a, abs_b;

  assign abs_a = (req.is_signed && req.a[31]) ? -req.a : req.a;
  assign abs_b = (req.is_signed && req.b[31]) ? -req.b : req.b;
  assign rem_sh = {rem[30:0], quo[31]};
  assign trial = {rem, quo[31]} - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt <= 6'd32;
        quo <= abs_a;
        dvs <= abs_b;
        rem <= '0;
        neg_q <= req.is_signed && (req.a[31] ^ req.b[31]);
        neg_r <= req.is_signed && req.a[31];
        want_rem <= req.rem;
      end else if (busy) begin
        if (!trial[32]) begin
          rem <= trial[31:0];
        end else begin
          rem <= rem_sh;
        end
        quo <= {quo[30:0], ~trial[32]};
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign result = want_rem ? (neg_r ? -rem : rem) : (neg_q ? -quo : quo);

  `include "rv32im_instruction_executor_defines.svh"
  `RVX_ASSERT_NXT(a_div_start_busy, clk, rst, req.start, busy)
  `RVX_ASSERT_IMP(a_div_done_idle, clk, rst, done, !busy)
  `RVX_ASSERT_IMP(a_div_cnt, clk, rst, busy, cnt != 6'd0)
endmodule

>>> src/rv32im_instruction_executor.sv
// Top level of the RV32IM executor
// One word at a time. An instruction word or a load data word passes through
// register read, execute and the result register after it is accepted;
// multiply adds a pass through the split partial products, divide and
// remainder add a pass through the bit-serial divider. The next word is accepted
// only once the result word has been taken. The register file is a
// synchronous RAM read through two ports; after reset a clearing pass
// zeroes its NUM_REGS entries, during which no word is accepted.
module rv32im_instruction_executor
  import rvx_pkg::*;
#(
  parameter int NUM_REGS = NumRegsDefault
) (
  input logic clk,
  input logic rst,
  rvx_if.sink in_ch,
  rvx_if.source out_ch
);
  localparam int AW = $clog2(NUM_REGS);

  state_t state, state_next;
  logic [31:0] pc;
  logic lpend;
  logic [4:0] ldest;
  logic [2:0] lws;
  logic func;
  logic [31:0] w, ldata;
  logic clearing;
  logic [AW:0] clr_cnt;
  result_t res, res_next;
  logic out_valid;

  logic we;
  logic [AW-1:0] waddr, ra, rb;
  logic [31:0] wdata, rda, rdb, a, b;
  logic [4:0] rs1, rs2, rd, op;
  logic [2:0] f3;
  logic [6:0] f7;
  logic [31:0] immi, imms, immb, immj;

  logic [31:0] p_ll;
  logic signed [33:0] p_lh, p_hl, p_hh;
  logic [32:0] ma, mb;
  logic [1:0] mstep;
  div_req_t dreq;
  logic ddone;
  logic [31:0] dres;

  assign in_ch.ready = (state == S_IDLE) && !clearing && !out_valid;
  assign out_ch.valid = out_valid;
  assign out_ch.data = res;

  assign op = w[6:2];
  assign f3 = w[14:12];
  assign f7 = w[31:25];
  assign rd = w[11:7];
  assign rs1 = w[19:15];
  assign rs2 = w[24:20];
  assign immi = {{20{w[31]}}, w[31:20]};
  assign imms = {{20{w[31]}}, w[31:25], w[11:7]};
  assign immb = {{20{w[31]}}, w[7], w[30:25], w[11:8], 1'b0};
  assign immj = {{12{w[31]}}, w[19:12], w[20], w[30:21], 1'b0};

  assign ra = w[15+AW-1:15];
  assign rb = w[20+AW-1:20];
  assign a = (rs1 == 5'd0 || 32'(rs1) >= NUM_REGS) ? 32'd0 : rda;
  assign b = (rs2 == 5'd0 || 32'(rs2) >= NUM_REGS) ? 32'd0 : rdb;

  rvx_ram #(.Width(32), .Depth(NUM_REGS)) u_rf (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
    .raddr_a(ra), .raddr_b(rb), .rdata_a(rda), .rdata_b(rdb)
  );

  rvx_div u_div (.clk(clk), .rst(rst), .req(dreq), .done(ddone), .result(dres));

  always_comb begin
    dreq.start = (state == S_EXEC) && !func && !lpend && w[1:0] == 2'b11 &&
                 op == OP_OP && f7 == F7_MUL && f3[2];
    dreq.is_signed = !f3[0];
    dreq.rem = f3[1];
    dreq.a = a;
    dreq.b = b;
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (in_ch.valid && in_ch.ready) state_next = S_READ;
      S_READ: state_next = S_EXEC;
      S_EXEC: begin
        if (!func && !lpend && op == OP_OP && f7 == F7_MUL && w[1:0] == 2'b11) begin
          state_next = f3[2] ? S_DIV : S_MUL;
        end else begin
          state_next = S_OUT;
        end
      end
      S_MUL: if (mstep == 2'd1) state_next = S_OUT;
      S_DIV: if (ddone) state_next = S_OUT;
      S_OUT: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  function automatic logic [31:0] alu(input logic [2:0] f, input logic alt,
                                       input logic [31:0] x, input logic [31:0] y);
    logic [31:0] r;
    case (f)
      3'd0: r = alt ? x - y : x + y;
      3'd1: r = x << y[4:0];
      3'd2: r = {31'd0, $signed(x) < $signed(y)};
      3'd3: r = {31'd0, x < y};
      3'd4: r = x ^ y;
      3'd5: r = alt ? 32'($signed(x) >>> y[4:0]) : x >> y[4:0];
      3'd6: r = x | y;
      default: r = x & y;
    endcase
    return r;
  endfunction

  function automatic logic [31:0] mux_div(input logic [2:0] f,
                                          input logic [31:0] x, input logic [31:0] y,
                                          input logic [31:0] q);
    logic [31:0] r;
    if (y == 32'd0) begin
      r = f[1] ? x : 32'hFFFFFFFF;
    end else if (!f[0] && x == 32'h80000000 && y == 32'hFFFFFFFF) begin
      r = f[1] ? 32'd0 : 32'h80000000;
    end else begin
      r = q;
    end
    return r;
  endfunction

  logic [63:0] mprod;
  assign mprod = {32'd0, p_ll} + {{14{p_lh[33]}}, p_lh, 16'd0} +
                 {{14{p_hl[33]}}, p_hl, 16'd0} + {p_hh[31:0], 32'd0};

  always_comb begin
    logic take, bad;
    logic [31:0] npc, dv, ld;
    logic wr;
    res_next = '0;
    res_next.next_pc = pc;
    take = 1'b0;
    bad = 1'b0;
    wr = 1'b0;
    dv = '0;
    npc = pc + 32'd4;
    ld = ldata;
    case (lws)
      3'd0: ld = {{24{ldata[7]}}, ldata[7:0]};
      3'd1: ld = {{16{ldata[15]}}, ldata[15:0]};
      3'd4: ld = {24'd0, ldata[7:0]};
      3'd5: ld = {16'd0, ldata[15:0]};
      default: ld = ldata;
    endcase
    if (func) begin
      if (!lpend) begin
        res_next.kind = K_UNEXPECTED;
      end else begin
        res_next.kind = K_RETIRE;
        wr = 1'b1;
        dv = ld;
        res_next.dest_reg = ldest;
      end
    end else if (lpend) begin
      res_next.kind = K_UNEXPECTED;
    end else if (w == 32'd0 || w[1:0] != 2'b11) begin
      bad = 1'b1;
    end else begin
      res_next.kind = K_RETIRE;
      res_next.dest_reg = rd;
      case (op)
        OP_LOAD: begin
          if (f3 == 3'd3 || f3 >= 3'd6) begin
            bad = 1'b1;
          end else begin
            res_next.kind = K_LOAD;
            res_next.mem_addr = a + immi;
            res_next.access_size = f3[1:0];
            res_next.dest_reg = '0;
          end
        end
        OP_FENCE: ;
        OP_IMM: begin
          if ((f3 == 3'd1 && f7 != 7'd0) ||
              (f3 == 3'd5 && f7 != 7'd0 && f7 != F7_ALT)) begin
            bad = 1'b1;
          end else begin
            wr = 1'b1;
            dv = alu(f3, f3 == 3'd5 && f7 == F7_ALT, a, immi);
          end
        end
        OP_AUIPC: begin
          wr = 1'b1;
          dv = pc + {w[31:12], 12'd0};
        end
        OP_STORE: begin
          if (f3 > 3'd2) begin
            bad = 1'b1;
          end else begin
            res_next.kind = K_STORE;
            res_next.mem_addr = a + imms;
            res_next.access_size = f3[1:0];
            res_next.store_data = f3 == 3'd0 ? {24'd0, b[7:0]} :
                                  f3 == 3'd1 ? {16'd0, b[15:0]} : b;
          end
        end
        OP_OP: begin
          wr = 1'b1;
          if (f7 == 7'd0) begin
            dv = alu(f3, 1'b0, a, b);
          end else if (f7 == F7_ALT && (f3 == 3'd0 || f3 == 3'd5)) begin
            dv = alu(f3, 1'b1, a, b);
          end else if (f7 == F7_MUL) begin
            case (f3)
              3'd0: dv = mprod[31:0];
              3'd1, 3'd2, 3'd3: dv = mprod[63:32];
              default: dv = mux_div(f3, a, b, dres);
            endcase
          end else begin
            bad = 1'b1;
          end
        end
        OP_LUI: begin
          wr = 1'b1;
          dv = {w[31:12], 12'd0};
        end
        OP_BRANCH: begin
          case (f3)
            3'd0: take = a == b;
            3'd1: take = a != b;
            3'd4: take = $signed(a) < $signed(b);
            3'd5: take = !($signed(a) < $signed(b));
            3'd6: take = a < b;
            3'd7: take = a >= b;
            default: bad = 1'b1;
          endcase
          if (take) npc = pc + immb;
        end
        OP_JALR: begin
          if (f3 != 3'd0) begin
            bad = 1'b1;
          end else begin
            npc = (a + immi) & ~32'd1;
            wr = 1'b1;
            dv = pc + 32'd4;
          end
        end
        OP_JAL: begin
          npc = pc + immj;
          wr = 1'b1;
          dv = pc + 32'd4;
        end
        OP_SYSTEM: begin
          if (f3 == 3'd0) begin
            if (rd != 5'd0 || rs1 != 5'd0) bad = 1'b1;
            else if (w[31:20] == 12'd0) res_next.kind = K_ECALL;
            else if (w[31:20] == 12'd1) res_next.kind = K_EBREAK;
            else bad = 1'b1;
          end else if (f3 == 3'd4) begin
            bad = 1'b1;
          end else if (f3 == 3'd1 && w[31:20] == CsrMvendorid) begin
            wr = 1'b1;
            dv = VendorId;
          end
        end
        default: bad = 1'b1;
      endcase
      if (!bad) res_next.next_pc = npc;
    end
    if (bad) begin
      res_next = '0;
      res_next.kind = K_ILLEGAL;
      res_next.next_pc = pc;
    end
    if (wr && res_next.dest_reg != 5'd0 && 32'(res_next.dest_reg) < NUM_REGS) begin
      res_next.reg_written = 1'b1;
      res_next.dest_value = dv;
    end else begin
      res_next.dest_reg = '0;
    end
  end

  always_comb begin
    we = 1'b0;
    waddr = res_next.dest_reg[AW-1:0];
    wdata = res_next.dest_value;
    if (clearing) begin
      we = 1'b1;
      waddr = clr_cnt[AW-1:0];
      wdata = '0;
    end else if (state == S_OUT) begin
      we = res_next.reg_written;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_EXEC) begin
      ma <= {f3 != 3'd3 && a[31], a};
      mb <= {f3 == 3'd1 && b[31], b};
    end
    p_ll <= ma[15:0] * mb[15:0];
    p_lh <= $signed({1'b0, ma[15:0]}) * $signed({mb[32], mb[31:16]});
    p_hl <= $signed({ma[32], ma[31:16]}) * $signed({1'b0, mb[15:0]});
    p_hh <= $signed({ma[32], ma[31:16]}) * $signed({mb[32], mb[31:16]});
    if (state == S_IDLE && in_ch.valid && in_ch.ready) begin
      func <= in_ch.data.func;
      w <= in_ch.data.instr_word;
      ldata <= in_ch.data.load_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      pc <= '0;
      lpend <= 1'b0;
      ldest <= '0;
      lws <= '0;
      clearing <= 1'b1;
      clr_cnt <= '0;
      out_valid <= 1'b0;
      mstep <= '0;
    end else begin
      state <= state_next;
      if (clearing) begin
        clr_cnt <= clr_cnt + 1'b1;
        if (32'(clr_cnt) == NUM_REGS - 1) clearing <= 1'b0;
      end
      if (state == S_EXEC) mstep <= 2'd3;
      else if (state == S_MUL) mstep <= mstep - 2'd1;
      if (out_ch.valid && out_ch.ready) out_valid <= 1'b0;
      if (state == S_OUT) begin
        out_valid <= 1'b1;
        res <= res_next;
        pc <= res_next.next_pc;
        if (res_next.kind == K_LOAD) begin
          lpend <= 1'b1;
          ldest <= rd;
          lws <= f3;
        end else if (func && lpend) begin
          lpend <= 1'b0;
        end
      end
    end
  end

  `include "rv32im_instruction_executor_defines.svh"
  `RVX_ASSERT_IMP(a_no_accept_clear, clk, rst, clearing, !in_ch.ready)
  `RVX_ASSERT_NXT(a_out_after_exec, clk, rst, state == S_OUT, out_valid)
  `RVX_ASSERT_IMP(a_ready_idle, clk, rst, in_ch.ready, state == S_IDLE && !out_valid)
endmodule
